// ===== design/mexp_pkg.sv =====
package mexp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_BIT,
		ST_MUL_ACC,
		ST_SQ_START,
		ST_MUL_PW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;       // capture a new item
		logic div_step;   // one restoring step of base mod modulus
		logic mul_start;  // seed a modular product
		logic mul_step;   // one shift-and-add doubling step
		logic mul_last;   // write the finished product back
		logic to_acc;     // product is acc*pw (else pw*pw)
		logic exp_shift;  // move to the next exponent bit
		logic res_load;   // load the output register
	} cmd_t;

	typedef struct packed {
		logic special;    // modulus zero or exponent zero
		logic exp_lsb;    // current exponent bit
	} sts_t;

endpackage

// ===== design/mexp_dp.sv =====
module mexp_dp #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  mexp_pkg::cmd_t     cmd,
	output mexp_pkg::sts_t     sts,
	input  logic [WIDTH-1:0]   base,
	input  logic [WIDTH-1:0]   exponent,
	input  logic [WIDTH-1:0]   modulus,
	output logic [WIDTH-1:0]   result
);

	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] dvd_q;
	logic [WIDTH-1:0] pw_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] prod_q;
	logic [WIDTH-1:0] dbl_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] result_q;
	logic             mod_zero_q;
	logic             exp_zero_q;

	logic [WIDTH:0]   rem_t;
	logic [WIDTH-1:0] rem_next;
	logic [WIDTH-1:0] prod_next;
	logic [WIDTH-1:0] dbl_next;
	logic [WIDTH-1:0] res_val;

	// (x + y) mod m for x, y < m
	function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
		input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] m);
		logic [WIDTH:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[WIDTH-1:0];
	endfunction

	always_comb begin
		rem_t = {pw_q, dvd_q[WIDTH-1]};
		if (rem_t >= {1'b0, m_q}) begin
			rem_next = WIDTH'(rem_t - {1'b0, m_q});
		end else begin
			rem_next = rem_t[WIDTH-1:0];
		end
	end

	assign prod_next = y_q[0] ? add_mod(prod_q, dbl_q, m_q) : prod_q;
	assign dbl_next  = add_mod(dbl_q, dbl_q, m_q);

	always_comb begin
		if (mod_zero_q) begin
			res_val = '0;
		end else if (exp_zero_q) begin
			res_val = WIDTH'(1);
		end else begin
			res_val = acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q        <= modulus;
			e_q        <= exponent;
			dvd_q      <= base;
			pw_q       <= '0;
			acc_q      <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
			mod_zero_q <= (modulus == '0);
			exp_zero_q <= (exponent == '0);
		end
		if (cmd.div_step) begin
			pw_q  <= rem_next;
			dvd_q <= dvd_q << 1;
		end
		if (cmd.mul_start) begin
			prod_q <= '0;
			dbl_q  <= cmd.to_acc ? acc_q : pw_q;
			y_q    <= pw_q;
		end
		if (cmd.mul_step) begin
			prod_q <= prod_next;
			dbl_q  <= dbl_next;
			y_q    <= y_q >> 1;
		end
		if (cmd.mul_last) begin
			if (cmd.to_acc) begin
				acc_q <= prod_next;
			end else begin
				pw_q <= prod_next;
			end
		end
		if (cmd.exp_shift) begin
			e_q <= e_q >> 1;
		end
		if (cmd.res_load) begin
			result_q <= res_val;
		end
	end

	assign sts.special = mod_zero_q | exp_zero_q;
	assign sts.exp_lsb = e_q[0];
	assign result      = result_q;

endmodule

// ===== design/mexp_ctrl.sv =====
module mexp_ctrl #(
	parameter int WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output mexp_pkg::cmd_t cmd,
	input  mexp_pkg::sts_t sts
);

	localparam int CW = $clog2(WIDTH);
	localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

	mexp_pkg::state_t state_q;
	mexp_pkg::state_t state_d;
	logic [CW-1:0]    step_q;
	logic [CW-1:0]    bit_q;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (in_valid) state_d = mexp_pkg::ST_REDUCE;
			end
			mexp_pkg::ST_REDUCE: begin
				if (sts.special) begin
					state_d = mexp_pkg::ST_DONE;
				end else if (step_q == LAST) begin
					state_d = mexp_pkg::ST_BIT;
				end
			end
			mexp_pkg::ST_BIT: begin
				state_d = sts.exp_lsb ? mexp_pkg::ST_MUL_ACC : mexp_pkg::ST_MUL_PW;
			end
			mexp_pkg::ST_MUL_ACC: begin
				if (step_q == LAST) state_d = mexp_pkg::ST_SQ_START;
			end
			mexp_pkg::ST_SQ_START: begin
				state_d = mexp_pkg::ST_MUL_PW;
			end
			mexp_pkg::ST_MUL_PW: begin
				if (step_q == LAST) begin
					state_d = (bit_q == LAST) ? mexp_pkg::ST_DONE : mexp_pkg::ST_BIT;
				end
			end
			mexp_pkg::ST_DONE: begin
				if (slot_free) state_d = mexp_pkg::ST_IDLE;
			end
			default: state_d = mexp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			mexp_pkg::ST_REDUCE: begin
				cmd.div_step = !sts.special;
			end
			mexp_pkg::ST_BIT: begin
				cmd.mul_start = 1'b1;
				cmd.to_acc    = sts.exp_lsb;
			end
			mexp_pkg::ST_MUL_ACC: begin
				cmd.mul_step = 1'b1;
				cmd.to_acc   = 1'b1;
				cmd.mul_last = (step_q == LAST);
			end
			mexp_pkg::ST_SQ_START: begin
				cmd.mul_start = 1'b1;
			end
			mexp_pkg::ST_MUL_PW: begin
				cmd.mul_step  = 1'b1;
				cmd.mul_last  = (step_q == LAST);
				cmd.exp_shift = (step_q == LAST);
			end
			mexp_pkg::ST_DONE: begin
				cmd.res_load = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexp_pkg::ST_IDLE;
			step_q      <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// step counter serves both the reduction and each product
			if (cmd.load || cmd.mul_start || cmd.mul_last) begin
				step_q <= '0;
			end else if (cmd.div_step || cmd.mul_step) begin
				step_q <= step_q + CW'(1);
			end
			if (cmd.load) begin
				bit_q <= '0;
			end else if (cmd.exp_shift) begin
				bit_q <= bit_q + CW'(1);
			end
			// hold the beat until taken
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/modular_exponentiation.sv =====
// Computes base ** exponent mod modulus on WIDTH-bit unsigned operands, one item at a
// time. An exponent of zero gives 1 (also for modulus 1); modulus zero gives 0. The base
// is first reduced by a restoring remainder unit, one bit a cycle. Then each exponent
// bit, LSB first, runs the shared shift-and-add modular multiplier: a one bit first adds
// a product into the running result, and every bit then squares the power. When exponent
// or modulus is zero, the reduction and the products are skipped. A finished result that
// still waits on the output holds the block until it is taken. A new item is taken while
// the previous result still waits on the output.
module modular_exponentiation #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] base,
	input  logic [WIDTH-1:0] exponent,
	input  logic [WIDTH-1:0] modulus,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] result
);

	mexp_pkg::cmd_t cmd;
	mexp_pkg::sts_t sts;

	mexp_ctrl #(
		.WIDTH (WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mexp_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.sts      (sts),
		.base     (base),
		.exponent (exponent),
		.modulus  (modulus),
		.result   (result)
	);

endmodule
